@@ sv/spv_pkg.sv @@
// ----------------------------------------------------------------------------
// spv_pkg
// Widths, codes and types shared by the space-time point voxelizer.
// ----------------------------------------------------------------------------
package spv_pkg;

    localparam int MODE_W     = 2;
    localparam int XY_W       = 10;
    localparam int T_W        = 16;
    localparam int SAMPLE_W   = 8;
    localparam int GRID_W     = 10;
    localparam int TC_W       = 15;
    localparam int DRIFT_W    = 16;
    localparam int SITE_W     = 32;
    localparam int KEY_W      = 30;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int REL_W  = 18;
    localparam int BASE_W = 12;
    localparam int PROD_W = DRIFT_W + REL_W;
    localparam int FRAC   = 15;
    localparam int DX_W   = PROD_W - FRAC;
    localparam int POS_W  = 21;
    localparam int M_W    = 2 * GRID_W;

    localparam int QUEUE_DEPTH = 4;

    localparam int TIME_WINDOW_DEF = 100;
    localparam int X_CENTRE_DEF    = 60;
    localparam int Y_CENTRE_DEF    = 80;

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(126);

    localparam logic [MODE_W-1:0] MODE_PICTURE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POINT   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_X_SHIFT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_SHIFT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_T_SHIFT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_CENTRE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_X_DRIFT     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_DRIFT     = 3'd6;

    typedef enum logic [1:0] {
        OP_PICTURE,
        OP_POINT,
        OP_CLEAR
    } op_t;

    typedef struct packed {
        logic [GRID_W-1:0]  grid_size;
        logic [XY_W-1:0]    x_shift;
        logic [XY_W-1:0]    y_shift;
        logic [T_W-1:0]     t_shift;
        logic [TC_W-1:0]    time_centre;
        logic [DRIFT_W-1:0] x_drift;
        logic [DRIFT_W-1:0] y_drift;
    } cfg_t;

    typedef struct packed {
        op_t                 op;
        logic [GRID_W-1:0]   p0;
        logic [GRID_W-1:0]   p1;
        logic [GRID_W-1:0]   p2;
        logic [SAMPLE_W-1:0] feature;
    } q_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ sv/spv_front.sv @@
// ----------------------------------------------------------------------------
// spv_front
// Accepts items, works out the sheared grid position of each point and
// classifies it; queues pictures, clears and in-grid, in-window points.
// ----------------------------------------------------------------------------
module spv_front #(
    parameter int TIME_WINDOW = spv_pkg::TIME_WINDOW_DEF,
    parameter int X_CENTRE    = spv_pkg::X_CENTRE_DEF,
    parameter int Y_CENTRE    = spv_pkg::Y_CENTRE_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  spv_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spv_pkg::MODE_W-1:0]    mode,
    input  logic [spv_pkg::XY_W-1:0]      pos_x,
    input  logic [spv_pkg::XY_W-1:0]      pos_y,
    input  logic [spv_pkg::T_W-1:0]       pos_t,
    input  logic [spv_pkg::SAMPLE_W-1:0]  sample,
    input  spv_pkg::q_status_t            q_stat,
    output logic                          q_push,
    output spv_pkg::q_entry_t             q_entry
);

    localparam logic signed [spv_pkg::BASE_W-1:0] XC = spv_pkg::BASE_W'(X_CENTRE);
    localparam logic signed [spv_pkg::BASE_W-1:0] YC = spv_pkg::BASE_W'(Y_CENTRE);
    localparam logic signed [spv_pkg::REL_W-1:0]  HW = spv_pkg::REL_W'(TIME_WINDOW / 2);
    localparam logic signed [spv_pkg::PROD_W-1:0] FRAC_MASK =
        spv_pkg::PROD_W'((2 ** spv_pkg::FRAC) - 1);

    // stage 1
    logic                                 s1_valid_reg, s1_valid_next;
    spv_pkg::op_t                         s1_op_reg, s1_op_next;
    logic signed [spv_pkg::REL_W-1:0]     s1_rel_reg, s1_rel_next;
    logic signed [spv_pkg::BASE_W-1:0]    s1_xb_reg, s1_xb_next;
    logic signed [spv_pkg::BASE_W-1:0]    s1_yb_reg, s1_yb_next;
    logic [spv_pkg::SAMPLE_W-1:0]         s1_sample_reg;
    // stage 2
    logic                                 s2_valid_reg;
    spv_pkg::op_t                         s2_op_reg;
    logic signed [spv_pkg::REL_W-1:0]     s2_rel_reg;
    logic signed [spv_pkg::BASE_W-1:0]    s2_xb_reg, s2_yb_reg;
    logic signed [spv_pkg::PROD_W-1:0]    s2_prodx_reg, s2_prodx_next;
    logic signed [spv_pkg::PROD_W-1:0]    s2_prody_reg, s2_prody_next;
    logic [spv_pkg::SAMPLE_W-1:0]         s2_sample_reg;

    logic s1_ready, s2_ready, s2_go, s2_keep;
    logic mode_known;

    logic signed [spv_pkg::PROD_W-1:0] sum_x, sum_y;
    logic signed [spv_pkg::DX_W-1:0]   dx, dy;
    logic signed [spv_pkg::POS_W-1:0]  half, size, p0, p1, p2;
    logic                              in_window;

    function automatic logic in_grid(
        input logic signed [spv_pkg::POS_W-1:0] p,
        input logic signed [spv_pkg::POS_W-1:0] s
    );
        return !p[spv_pkg::POS_W-1] && (p < s);
    endfunction

    // classify mode
    always_comb
    begin
        mode_known = 1'b1;
        s1_op_next = spv_pkg::OP_PICTURE;
        unique case (mode)
            spv_pkg::MODE_PICTURE: s1_op_next = spv_pkg::OP_PICTURE;
            spv_pkg::MODE_POINT:   s1_op_next = spv_pkg::OP_POINT;
            spv_pkg::MODE_CLEAR:   s1_op_next = spv_pkg::OP_CLEAR;
            default:               mode_known = 1'b0;
        endcase
    end

    assign s1_valid_next = in_valid && mode_known;
    assign s1_rel_next   = spv_pkg::REL_W'($signed({2'b00, pos_t}))
                         - spv_pkg::REL_W'($signed({3'b000, cfg.time_centre}))
                         + spv_pkg::REL_W'($signed(cfg.t_shift));
    assign s1_xb_next    = spv_pkg::BASE_W'($signed(pos_x)) - XC
                         + spv_pkg::BASE_W'($signed(cfg.x_shift));
    assign s1_yb_next    = spv_pkg::BASE_W'($signed(pos_y)) - YC
                         + spv_pkg::BASE_W'($signed(cfg.y_shift));

    assign s2_prodx_next = $signed(cfg.x_drift) * s1_rel_reg;
    assign s2_prody_next = $signed(cfg.y_drift) * s1_rel_reg;

    // truncate toward zero
    assign sum_x = s2_prodx_reg + (s2_prodx_reg[spv_pkg::PROD_W-1] ? FRAC_MASK : '0);
    assign sum_y = s2_prody_reg + (s2_prody_reg[spv_pkg::PROD_W-1] ? FRAC_MASK : '0);
    assign dx    = sum_x[spv_pkg::PROD_W-1:spv_pkg::FRAC];
    assign dy    = sum_y[spv_pkg::PROD_W-1:spv_pkg::FRAC];

    assign half = $signed(spv_pkg::POS_W'(cfg.grid_size >> 1));
    assign size = $signed(spv_pkg::POS_W'(cfg.grid_size));
    assign p0   = spv_pkg::POS_W'(s2_xb_reg) + spv_pkg::POS_W'(dx) + half;
    assign p1   = spv_pkg::POS_W'(s2_yb_reg) + spv_pkg::POS_W'(dy) + half;
    assign p2   = spv_pkg::POS_W'(s2_rel_reg) + half;

    assign in_window = (s2_rel_reg < HW) && (s2_rel_reg > -HW);

    assign s2_keep = (s2_op_reg != spv_pkg::OP_POINT)
                   || (in_grid(p0, size) && in_grid(p1, size) && in_grid(p2, size)
                       && in_window);

    assign q_push   = s2_valid_reg && s2_keep && !q_stat.full;
    assign s2_go    = s2_valid_reg && (!s2_keep || !q_stat.full);
    assign s2_ready = !s2_valid_reg || s2_go;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    assign q_entry.op      = s2_op_reg;
    assign q_entry.p0      = p0[spv_pkg::GRID_W-1:0];
    assign q_entry.p1      = p1[spv_pkg::GRID_W-1:0];
    assign q_entry.p2      = p2[spv_pkg::GRID_W-1:0];
    assign q_entry.feature = s2_sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= s1_valid_next;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_op_reg     <= s1_op_next;
            s1_rel_reg    <= s1_rel_next;
            s1_xb_reg     <= s1_xb_next;
            s1_yb_reg     <= s1_yb_next;
            s1_sample_reg <= sample;
        end
        if (s2_ready)
        begin
            s2_op_reg     <= s1_op_reg;
            s2_rel_reg    <= s1_rel_reg;
            s2_xb_reg     <= s1_xb_reg;
            s2_yb_reg     <= s1_yb_reg;
            s2_prodx_reg  <= s2_prodx_next;
            s2_prody_reg  <= s2_prody_next;
            s2_sample_reg <= s1_sample_reg;
        end
    end

endmodule

@@ sv/spv_queue.sv @@
// ----------------------------------------------------------------------------
// spv_queue
// Short first-in first-out queue of classified items between front and back.
// ----------------------------------------------------------------------------
module spv_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  spv_pkg::q_entry_t  push_entry,
    input  logic               pop,
    output spv_pkg::q_entry_t  pop_entry,
    output spv_pkg::q_status_t status
);

    localparam int DEPTH = spv_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    spv_pkg::q_entry_t slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_entry    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

@@ sv/spv_back.sv @@
// ----------------------------------------------------------------------------
// spv_back
// Pops queued items, builds the cell key, numbers the sites and holds the
// result in the output register.
// ----------------------------------------------------------------------------
module spv_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [spv_pkg::GRID_W-1:0]    grid_size,
    input  spv_pkg::q_status_t            q_stat,
    input  spv_pkg::q_entry_t             q_entry,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          kind,
    output logic [spv_pkg::SITE_W-1:0]    site_number,
    output logic [spv_pkg::KEY_W-1:0]     grid_key,
    output logic [spv_pkg::SAMPLE_W-1:0]  feature
);

    logic                            b1_valid_reg;
    spv_pkg::q_entry_t               b1_entry_reg;
    logic [spv_pkg::M_W-1:0]         b1_m_reg, b1_m_next;

    logic                            out_valid_reg, out_valid_next;
    logic                            kind_reg, kind_next;
    logic [spv_pkg::SITE_W-1:0]      site_reg, site_next;
    logic [spv_pkg::KEY_W-1:0]       key_reg, key_next;
    logic [spv_pkg::SAMPLE_W-1:0]    feature_reg, feature_next;
    logic [spv_pkg::SITE_W-1:0]      site_count_reg, site_count_next;

    logic b1_ready, b1_go, out_load, is_clear, is_point;

    assign is_clear = (b1_entry_reg.op == spv_pkg::OP_CLEAR);
    assign is_point = (b1_entry_reg.op == spv_pkg::OP_POINT);

    assign b1_go    = b1_valid_reg && (is_clear || !out_valid_reg || out_ready);
    assign b1_ready = !b1_valid_reg || b1_go;
    assign q_pop    = b1_ready && !q_stat.empty;
    assign out_load = b1_go && !is_clear;

    assign b1_m_next = spv_pkg::M_W'(q_entry.p0) * spv_pkg::M_W'(grid_size)
                     + spv_pkg::M_W'(q_entry.p1);

    always_comb
    begin
        kind_next       = is_point;
        site_next       = site_count_reg;
        key_next        = '0;
        feature_next    = '0;
        site_count_next = site_count_reg;
        if (is_point)
        begin
            key_next     = spv_pkg::KEY_W'(b1_m_reg) * spv_pkg::KEY_W'(grid_size)
                         + spv_pkg::KEY_W'(b1_entry_reg.p2);
            feature_next = b1_entry_reg.feature;
        end
        if (b1_go)
        begin
            site_count_next = is_clear ? '0 : site_count_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            site_count_reg <= '0;
        end
        else
        begin
            if (b1_ready)
            begin
                b1_valid_reg <= !q_stat.empty;
            end
            out_valid_reg  <= out_valid_next;
            site_count_reg <= site_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_entry_reg <= q_entry;
            b1_m_reg     <= b1_m_next;
        end
        if (out_load)
        begin
            kind_reg    <= kind_next;
            site_reg    <= site_next;
            key_reg     <= key_next;
            feature_reg <= feature_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign site_number = site_reg;
    assign grid_key    = key_reg;
    assign feature     = feature_reg;

endmodule

@@ sv/spacetime_point_voxelizer.sv @@
// ----------------------------------------------------------------------------
// spacetime_point_voxelizer
// Places space-time points into a cubic sparse grid and numbers the sites.
// The block takes one item per cycle at its sustained rate while the output
// is not stalled. Two front stages come first: relative time and offsets,
// then the two velocity multiplies, with truncation and range checks ahead
// of the queue write. Each kept item then passes through the four-item queue.
// Two back stages follow: the key multiply-add and the output register
// holding the numbered site. The front and the back stall apart, so a
// waiting result holds back the input only once the queue is full. Rejected
// points and unused mode codes are dropped in the front. The configuration
// port takes a register index and 16 data bits, with cfg_ready always high;
// write it only while no item is in flight.
// ----------------------------------------------------------------------------
module spacetime_point_voxelizer #(
    parameter int TIME_WINDOW = spv_pkg::TIME_WINDOW_DEF,
    parameter int X_CENTRE    = spv_pkg::X_CENTRE_DEF,
    parameter int Y_CENTRE    = spv_pkg::Y_CENTRE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [spv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [spv_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [spv_pkg::MODE_W-1:0]      mode,
    input  logic [spv_pkg::XY_W-1:0]        pos_x,
    input  logic [spv_pkg::XY_W-1:0]        pos_y,
    input  logic [spv_pkg::T_W-1:0]         pos_t,
    input  logic [spv_pkg::SAMPLE_W-1:0]    sample,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            kind,
    output logic [spv_pkg::SITE_W-1:0]      site_number,
    output logic [spv_pkg::KEY_W-1:0]       grid_key,
    output logic [spv_pkg::SAMPLE_W-1:0]    feature
);

    spv_pkg::cfg_t      cfg_reg, cfg_next;
    spv_pkg::q_status_t q_stat;
    spv_pkg::q_entry_t  q_push_entry, q_pop_entry;
    logic               q_push, q_pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                spv_pkg::CFG_GRID_SIZE:   cfg_next.grid_size   = cfg_data[spv_pkg::GRID_W-1:0];
                spv_pkg::CFG_X_SHIFT:     cfg_next.x_shift     = cfg_data[spv_pkg::XY_W-1:0];
                spv_pkg::CFG_Y_SHIFT:     cfg_next.y_shift     = cfg_data[spv_pkg::XY_W-1:0];
                spv_pkg::CFG_T_SHIFT:     cfg_next.t_shift     = cfg_data[spv_pkg::T_W-1:0];
                spv_pkg::CFG_TIME_CENTRE: cfg_next.time_centre = cfg_data[spv_pkg::TC_W-1:0];
                spv_pkg::CFG_X_DRIFT:     cfg_next.x_drift     = cfg_data[spv_pkg::DRIFT_W-1:0];
                spv_pkg::CFG_Y_DRIFT:     cfg_next.y_drift     = cfg_data[spv_pkg::DRIFT_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{grid_size: spv_pkg::GRID_RESET, default: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    spv_front #(
        .TIME_WINDOW (TIME_WINDOW),
        .X_CENTRE    (X_CENTRE),
        .Y_CENTRE    (Y_CENTRE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .mode     (mode),
        .pos_x    (pos_x),
        .pos_y    (pos_y),
        .pos_t    (pos_t),
        .sample   (sample),
        .q_stat   (q_stat),
        .q_push   (q_push),
        .q_entry  (q_push_entry)
    );

    spv_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .status     (q_stat)
    );

    spv_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .grid_size   (cfg_reg.grid_size),
        .q_stat      (q_stat),
        .q_entry     (q_pop_entry),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .site_number (site_number),
        .grid_key    (grid_key),
        .feature     (feature)
    );

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("item pushed into a full queue");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("item popped from an empty queue");

    a_background_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !kind) |-> (grid_key == '0 && feature == '0))
        else $error("background site carries a key or feature");

endmodule

@@ sim/tb_spacetime_point_voxelizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_spacetime_point_voxelizer
// Streams picture, point, clear and unused-mode items through the voxelizer
// under random source gaps and sink stalls, across several register settings,
// and checks every numbered site against a cycle-free model of the grid mapping.
// ----------------------------------------------------------------------------
module tb_spacetime_point_voxelizer;

    localparam logic [spv_pkg::MODE_W-1:0]    MODE_UNUSED = 2'd3;
    localparam logic [spv_pkg::CFG_IDX_W-1:0] CFG_UNUSED  = 3'd7;

    typedef struct {
        logic                         kind;
        logic [spv_pkg::SITE_W-1:0]   site;
        logic [spv_pkg::KEY_W-1:0]    key;
        logic [spv_pkg::SAMPLE_W-1:0] feat;
    } site_rec_t;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [spv_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [spv_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                           in_valid;
    logic                           in_ready;
    logic [spv_pkg::MODE_W-1:0]     mode;
    logic [spv_pkg::XY_W-1:0]       pos_x;
    logic [spv_pkg::XY_W-1:0]       pos_y;
    logic [spv_pkg::T_W-1:0]        pos_t;
    logic [spv_pkg::SAMPLE_W-1:0]   sample;
    logic                           out_valid;
    logic                           out_ready;
    logic                           kind;
    logic [spv_pkg::SITE_W-1:0]     site_number;
    logic [spv_pkg::KEY_W-1:0]      grid_key;
    logic [spv_pkg::SAMPLE_W-1:0]   feature;

    spv_pkg::cfg_t              grid_cfg;
    logic [spv_pkg::SITE_W-1:0] next_site;
    site_rec_t                  sites_due[$];
    int                         mismatches;
    int                         hold_len;
    bit                         tx_calm;
    bit                         rx_calm;

    spacetime_point_voxelizer u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint drift_offset(input logic [spv_pkg::DRIFT_W-1:0] vel,
                                            input longint rel);
        return (longint'($signed(vel)) * rel) / 32768;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        mismatches++;
    endtask

    task automatic add_due_site(input site_rec_t rec);
        sites_due = {sites_due, rec};
    endtask

    task automatic place_item(input logic [spv_pkg::MODE_W-1:0] m,
                              input logic [spv_pkg::XY_W-1:0] x,
                              input logic [spv_pkg::XY_W-1:0] y,
                              input logic [spv_pkg::T_W-1:0] t,
                              input logic [spv_pkg::SAMPLE_W-1:0] s);
        longint    sz, half, rel, p0, p1, p2, arel;
        site_rec_t rec;
        case (m)
            spv_pkg::MODE_PICTURE:
            begin
                rec = '{1'b0, next_site, '0, '0};
                add_due_site(rec);
                next_site++;
            end
            spv_pkg::MODE_CLEAR:
                next_site = '0;
            spv_pkg::MODE_POINT:
            begin
                sz   = longint'(grid_cfg.grid_size);
                half = sz / 2;
                rel  = longint'(t) - longint'(grid_cfg.time_centre)
                       + longint'($signed(grid_cfg.t_shift));
                p0   = longint'($signed(x)) - spv_pkg::X_CENTRE_DEF
                       + longint'($signed(grid_cfg.x_shift))
                       + drift_offset(grid_cfg.x_drift, rel) + half;
                p1   = longint'($signed(y)) - spv_pkg::Y_CENTRE_DEF
                       + longint'($signed(grid_cfg.y_shift))
                       + drift_offset(grid_cfg.y_drift, rel) + half;
                p2   = rel + half;
                arel = rel < 0 ? -rel : rel;
                if (p0 >= 0 && p1 >= 0 && p2 >= 0 && p0 < sz && p1 < sz && p2 < sz
                    && arel < spv_pkg::TIME_WINDOW_DEF / 2)
                begin
                    rec.kind = 1'b1;
                    rec.site = next_site;
                    rec.key  = spv_pkg::KEY_W'(p0 * sz * sz + p1 * sz + p2);
                    rec.feat = s;
                    add_due_site(rec);
                    next_site++;
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [spv_pkg::MODE_W-1:0] m,
                             input logic [spv_pkg::XY_W-1:0] x,
                             input logic [spv_pkg::XY_W-1:0] y,
                             input logic [spv_pkg::T_W-1:0] t,
                             input logic [spv_pkg::SAMPLE_W-1:0] s);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        pos_x    <= x;
        pos_y    <= y;
        pos_t    <= t;
        sample   <= s;
        do @(posedge clk); while (!in_ready);
        place_item(m, x, y, t, s);
    endtask

    task automatic write_reg(input logic [spv_pkg::CFG_IDX_W-1:0] idx,
                             input logic [spv_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            spv_pkg::CFG_GRID_SIZE:   grid_cfg.grid_size   = data[spv_pkg::GRID_W-1:0];
            spv_pkg::CFG_X_SHIFT:     grid_cfg.x_shift     = data[spv_pkg::XY_W-1:0];
            spv_pkg::CFG_Y_SHIFT:     grid_cfg.y_shift     = data[spv_pkg::XY_W-1:0];
            spv_pkg::CFG_T_SHIFT:     grid_cfg.t_shift     = data[spv_pkg::T_W-1:0];
            spv_pkg::CFG_TIME_CENTRE: grid_cfg.time_centre = data[spv_pkg::TC_W-1:0];
            spv_pkg::CFG_X_DRIFT:     grid_cfg.x_drift     = data[spv_pkg::DRIFT_W-1:0];
            spv_pkg::CFG_Y_DRIFT:     grid_cfg.y_drift     = data[spv_pkg::DRIFT_W-1:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input logic [15:0] gs, input logic [15:0] xs, input logic [15:0] ys,
                             input logic [15:0] ts, input logic [15:0] tc,
                             input logic [15:0] xd, input logic [15:0] yd);
        write_reg(spv_pkg::CFG_GRID_SIZE, gs);
        write_reg(spv_pkg::CFG_X_SHIFT, xs);
        write_reg(spv_pkg::CFG_Y_SHIFT, ys);
        write_reg(spv_pkg::CFG_T_SHIFT, ts);
        write_reg(spv_pkg::CFG_TIME_CENTRE, tc);
        write_reg(spv_pkg::CFG_X_DRIFT, xd);
        write_reg(spv_pkg::CFG_Y_DRIFT, yd);
    endtask

    task automatic settle_block();
        int guard;
        in_valid <= 1'b0;
        guard = 0;
        while (sites_due.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);
    endtask

    task automatic point(input int x, input int y, input int t, input int s);
        send_item(spv_pkg::MODE_POINT, spv_pkg::XY_W'(x), spv_pkg::XY_W'(y),
                  spv_pkg::T_W'(t), spv_pkg::SAMPLE_W'(s));
    endtask

    task automatic picture();
        send_item(spv_pkg::MODE_PICTURE, spv_pkg::XY_W'($urandom), spv_pkg::XY_W'($urandom),
                  spv_pkg::T_W'($urandom), spv_pkg::SAMPLE_W'($urandom));
    endtask

    // aim at the grid edges and the time window
    task automatic aimed_point();
        longint sz, half, r, px, py, pt;
        sz   = longint'(grid_cfg.grid_size);
        half = sz / 2;
        r    = longint'($urandom_range(110)) - 55;
        pt   = longint'(grid_cfg.time_centre) - longint'($signed(grid_cfg.t_shift)) + r;
        px   = longint'($urandom_range(int'(sz) + 3)) - 2 - half
               - longint'($signed(grid_cfg.x_shift)) - drift_offset(grid_cfg.x_drift, r)
               + spv_pkg::X_CENTRE_DEF;
        py   = longint'($urandom_range(int'(sz) + 3)) - 2 - half
               - longint'($signed(grid_cfg.y_shift)) - drift_offset(grid_cfg.y_drift, r)
               + spv_pkg::Y_CENTRE_DEF;
        send_item(spv_pkg::MODE_POINT, spv_pkg::XY_W'(px), spv_pkg::XY_W'(py),
                  spv_pkg::T_W'(pt), spv_pkg::SAMPLE_W'($urandom));
    endtask

    task automatic random_item();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            picture();
        else if (pick < 13)
            send_item(spv_pkg::MODE_CLEAR, spv_pkg::XY_W'($urandom), spv_pkg::XY_W'($urandom),
                      spv_pkg::T_W'($urandom), spv_pkg::SAMPLE_W'($urandom));
        else if (pick < 16)
            send_item(MODE_UNUSED, spv_pkg::XY_W'($urandom), spv_pkg::XY_W'($urandom),
                      spv_pkg::T_W'($urandom), spv_pkg::SAMPLE_W'($urandom));
        else if (pick < 80)
            aimed_point();
        else
            send_item(spv_pkg::MODE_POINT, spv_pkg::XY_W'($urandom), spv_pkg::XY_W'($urandom),
                      spv_pkg::T_W'($urandom), spv_pkg::SAMPLE_W'($urandom));
    endtask

    task automatic test_reset_settings();
        tx_calm = 1'b0;
        rx_calm = 1'b0;
        picture();
        point(60, 80, 0, 0);
        point(60, 80, 0, 255);
        point(-3, 80, 49, 8'h55);
        point(122, 80, 1, 8'hAA);
        point(123, 80, 1, 1);
        point(-4, 80, 1, 2);
        point(60, 17, 2, 3);
        point(60, 142, 3, 4);
        point(60, 143, 3, 5);
        point(60, 80, 50, 6);
        point(-512, -512, 0, 7);
        point(511, 511, 65535, 8);
        send_item(MODE_UNUSED, spv_pkg::XY_W'(60), spv_pkg::XY_W'(80), spv_pkg::T_W'(0),
                  spv_pkg::SAMPLE_W'(9));
        send_item(spv_pkg::MODE_CLEAR, spv_pkg::XY_W'(60), spv_pkg::XY_W'(80),
                  spv_pkg::T_W'(0), spv_pkg::SAMPLE_W'(10));
        picture();
        point(60, 80, 10, 128);
        settle_block();
    endtask

    task automatic test_register_extremes();
        // largest grid, offsets and drifts at their limits, centre at the top
        write_all(16'hFFFF, 16'h01FF, 16'h0200, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000);
        write_reg(CFG_UNUSED, 16'hFFFF);
        point(60, 81, 65535, 1);
        point(-512, 511, 65535, 2);
        point(60, 81, 65486, 3);
        point(0, 100, 65485, 4);
        point(60, 81, 65534, 5);
        point(511, -512, 65500, 6);
        picture();
        settle_block();
        // single-cell grid: only the exact centre at zero relative time lands
        write_all(16'hFC01, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF);
        point(60, 80, 0, 255);
        point(61, 80, 0, 1);
        point(60, 79, 0, 1);
        point(60, 80, 1, 1);
        picture();
        settle_block();
    endtask

    task automatic test_zero_grid();
        write_reg(spv_pkg::CFG_GRID_SIZE, 16'h0000);
        picture();
        point(60, 80, 0, 1);
        point(0, 0, 0, 2);
        picture();
        settle_block();
    endtask

    task automatic test_random_settings();
        int grid;
        repeat (6)
        begin
            case ($urandom_range(4))
                0: grid = 1023;
                1: grid = 1;
                2: grid = 2;
                default: grid = $urandom_range(1, 1023);
            endcase
            write_all({6'($urandom), 10'(grid)}, 16'($urandom), 16'($urandom),
                      16'($urandom_range(400) - 200), 16'($urandom),
                      16'($urandom), 16'($urandom));
            if ($urandom_range(3) == 0)
                write_reg(CFG_UNUSED, 16'($urandom));
            tx_calm = ($urandom_range(3) == 0);
            rx_calm = ($urandom_range(3) == 0);
            repeat (90) random_item();
            settle_block();
        end
        tx_calm = 1'b0;
        rx_calm = 1'b0;
    endtask

    task automatic test_backpressure();
        tx_calm  = 1'b1;
        hold_len = 80;
        repeat (40) picture();
        tx_calm = 1'b0;
        settle_block();
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= spv_pkg::MODE_PICTURE;
        pos_x     <= '0;
        pos_y     <= '0;
        pos_t     <= '0;
        sample    <= '0;
        grid_cfg  = '0;
        grid_cfg.grid_size = spv_pkg::GRID_RESET;
        next_site = '0;
        mismatches = 0;
        hold_len  = 0;
        tx_calm   = 1'b0;
        rx_calm   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_settings();
        test_register_extremes();
        test_zero_grid();
        test_random_settings();
        test_backpressure();

        if (sites_due.size() != 0)
            report_mismatch("sites never emitted", sites_due.size(), 0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_len > 0)
            begin
                stall    = hold_len;
                hold_len = 0;
            end
            else
                stall = rx_calm ? 0 : $urandom_range(3);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid && hold_len == 0);
        end
    end

    initial
    begin
        site_rec_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (sites_due.size() == 0)
                    report_mismatch("unexpected site", site_number, 0);
                else
                begin
                    want = sites_due.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (site_number !== want.site)
                        report_mismatch("site_number", site_number, want.site);
                    if (grid_key !== want.key)
                        report_mismatch("grid_key", grid_key, want.key);
                    if (feature !== want.feat)
                        report_mismatch("feature", feature, want.feat);
                end
            end
        end
    end

endmodule

@@ sim.f @@
sv/spv_pkg.sv
sv/spv_front.sv
sv/spv_queue.sv
sv/spv_back.sv
sv/spacetime_point_voxelizer.sv
sim/tb_spacetime_point_voxelizer.sv
